// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that must hold at every rising clock edge outside reset.
`define TCBS_ASSERT(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("tcbs assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define TCBS_ASSERT_IMPL(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("tcbs implication failed");

`endif

// ----- rtl/tcbs_pkg.sv -----
// Shared constants, types and state encoding of the cut height search unit.
package tcbs_pkg;

	localparam int MAX_ITEMS    = 1024;
	localparam int LENGTH_WIDTH = 20;
	localparam int ADDR_W       = $clog2(MAX_ITEMS);
	localparam int CNT_W        = $clog2(MAX_ITEMS + 1);
	localparam int SUM_W        = LENGTH_WIDTH + CNT_W;
	localparam int SLICE_W      = 8;
	localparam int NUM_CELLS    = (SUM_W + SLICE_W - 1) / SLICE_W;
	localparam int CHAIN_W      = NUM_CELLS * SLICE_W;
	localparam int DRAIN_W      = $clog2(NUM_CELLS + 2);
	localparam int TARGET_W     = 30;
	localparam int APB_DATA_W   = 32;
	localparam int PADDR_W      = 3;
	localparam int REG_IDX_W    = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_TARGET_TOTAL = '0;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PROBE,
		ST_WALK,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               clear;
		logic               carry;
		logic [CHAIN_W-1:0] addend;
	} cell_link_t;

endpackage

// ----- rtl/threshold_cut_binary_search_unit.sv -----
// Top level of the cut height search unit: loader, search sequencer and accumulator chain.
// Lengths are taken one per cycle while loading and written to a 1024-entry store; the
// transaction marked last closes the set and starts a binary search over cut heights 0
// to the set's maximum. Each probe reads the N stored lengths through the store's single
// read port, one per cycle, and feeds their excess into a chain of NUM_CELLS
// carry-pipelined adder cells. A set needs at most LENGTH_WIDTH + 1 probes, and no lengths
// are taken during the search. The result is held in an output register, and loading of
// the next set may start while it still waits to be taken.
`include "assert_macros.svh"

module threshold_cut_binary_search_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [tcbs_pkg::PADDR_W-1:0]           paddr,
	input  logic [tcbs_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [tcbs_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [tcbs_pkg::LENGTH_WIDTH-1:0]      length,
	input  logic                                   last,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [tcbs_pkg::LENGTH_WIDTH-1:0]      cut_height,
	output logic                                   exact_match,
	output logic                                   overflow,
	output logic                                   empty_set
);

	localparam int LW = tcbs_pkg::LENGTH_WIDTH;

	tcbs_pkg::state_t                state_q, state_d;
	logic [tcbs_pkg::CNT_W-1:0]      item_count_q, item_count_d;
	logic [LW-1:0]                   max_length_q, max_length_d;
	logic                            overflow_q, overflow_d;
	logic [tcbs_pkg::TARGET_W-1:0]   target_q;
	logic [LW:0]                     lo_q, lo_d, hi1_q, hi1_d;
	logic [LW-1:0]                   mid_q, mid_d, answer_q, answer_d;
	logic                            exact_q, exact_d, empty_q, empty_d;
	logic [tcbs_pkg::CNT_W-1:0]      walk_q, walk_d;
	logic [tcbs_pkg::DRAIN_W-1:0]    drain_q, drain_d;
	logic                            out_valid_q, out_valid_d;
	logic [LW-1:0]                   cut_height_q;
	logic                            exact_out_q, overflow_out_q, empty_out_q;
	logic                            load_out;

	logic                            in_accept, store_ok, ram_we, ram_re, cfg_write;
	logic [LW-1:0]                   ram_rdata;
	logic [LW+1:0]                   mid_sum;
	logic                            rv_s1, first_s1;
	logic [LW-1:0]                   excess_s2;
	logic                            v_s2, first_s2;
	logic [LW-1:0]                   excess;

	tcbs_pkg::cell_link_t            link [tcbs_pkg::NUM_CELLS+1];
	logic [tcbs_pkg::SLICE_W-1:0]    acc_slice [tcbs_pkg::NUM_CELLS];
	logic [tcbs_pkg::CHAIN_W-1:0]    chain_sum;
	logic [tcbs_pkg::CHAIN_W-1:0]    target_ext;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr[tcbs_pkg::PADDR_W-1:2] == tcbs_pkg::REG_TARGET_TOTAL);
	assign prdata    = (paddr[tcbs_pkg::PADDR_W-1:2] == tcbs_pkg::REG_TARGET_TOTAL)
		? tcbs_pkg::APB_DATA_W'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_write) begin
			target_q <= pwdata[tcbs_pkg::TARGET_W-1:0];
		end
	end

	assign in_accept = in_valid && !in_stall;
	assign store_ok  = (item_count_q < tcbs_pkg::CNT_W'(tcbs_pkg::MAX_ITEMS));
	assign ram_we    = in_accept && store_ok;
	assign ram_re    = (state_q == tcbs_pkg::ST_WALK);
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi1_q} - (LW+2)'(1);
	assign load_out  = (state_q == tcbs_pkg::ST_FINISH) && (!out_valid_q || !out_stall);

	tcbs_ram #(
		.DATA_W (LW),
		.DEPTH  (tcbs_pkg::MAX_ITEMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (item_count_q[tcbs_pkg::ADDR_W-1:0]),
		.wdata (length),
		.re    (ram_re),
		.raddr (walk_q[tcbs_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// Sequencer: next state and control values.
	always_comb begin
		state_d      = state_q;
		item_count_d = item_count_q;
		max_length_d = max_length_q;
		overflow_d   = overflow_q;
		lo_d         = lo_q;
		hi1_d        = hi1_q;
		mid_d        = mid_q;
		answer_d     = answer_q;
		exact_d      = exact_q;
		empty_d      = empty_q;
		walk_d       = walk_q;
		drain_d      = drain_q;
		out_valid_d  = out_valid_q && out_stall;
		in_stall     = 1'b1;
		unique case (state_q)
			tcbs_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (store_ok) begin
						item_count_d = item_count_q + tcbs_pkg::CNT_W'(1);
						if (length > max_length_q) begin
							max_length_d = length;
						end
					end else begin
						overflow_d = 1'b1;
					end
					if (last) begin
						lo_d     = '0;
						hi1_d    = {1'b0, max_length_d} + (LW+1)'(1);
						answer_d = '0;
						exact_d  = 1'b0;
						empty_d  = 1'b0;
						state_d  = tcbs_pkg::ST_PROBE;
					end
				end
			end
			tcbs_pkg::ST_PROBE: begin
				if (item_count_q == '0) begin
					empty_d = 1'b1;
					state_d = tcbs_pkg::ST_FINISH;
				end else if (lo_q < hi1_q) begin
					mid_d   = mid_sum[LW:1];
					walk_d  = '0;
					state_d = tcbs_pkg::ST_WALK;
				end else begin
					state_d = tcbs_pkg::ST_FINISH;
				end
			end
			tcbs_pkg::ST_WALK: begin
				walk_d = walk_q + tcbs_pkg::CNT_W'(1);
				if (walk_d == item_count_q) begin
					drain_d = tcbs_pkg::DRAIN_W'(tcbs_pkg::NUM_CELLS);
					state_d = tcbs_pkg::ST_DRAIN;
				end
			end
			tcbs_pkg::ST_DRAIN: begin
				drain_d = drain_q - tcbs_pkg::DRAIN_W'(1);
				if (drain_q == '0) begin
					state_d = tcbs_pkg::ST_DECIDE;
				end
			end
			tcbs_pkg::ST_DECIDE: begin
				priority if (chain_sum < target_ext) begin
					hi1_d   = {1'b0, mid_q};
					state_d = tcbs_pkg::ST_PROBE;
				end else if (chain_sum > target_ext) begin
					answer_d = mid_q;
					lo_d     = {1'b0, mid_q} + (LW+1)'(1);
					state_d  = tcbs_pkg::ST_PROBE;
				end else begin
					answer_d = mid_q;
					exact_d  = 1'b1;
					state_d  = tcbs_pkg::ST_FINISH;
				end
			end
			tcbs_pkg::ST_FINISH: begin
				if (load_out) begin
					out_valid_d  = 1'b1;
					item_count_d = '0;
					max_length_d = '0;
					overflow_d   = 1'b0;
					state_d      = tcbs_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = tcbs_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcbs_pkg::ST_LOAD;
			item_count_q <= '0;
			max_length_q <= '0;
			overflow_q   <= 1'b0;
			lo_q         <= '0;
			hi1_q        <= '0;
			mid_q        <= '0;
			answer_q     <= '0;
			exact_q      <= 1'b0;
			empty_q      <= 1'b0;
			walk_q       <= '0;
			drain_q      <= '0;
			out_valid_q  <= 1'b0;
			rv_s1        <= 1'b0;
			first_s1     <= 1'b0;
			v_s2         <= 1'b0;
			first_s2     <= 1'b0;
		end else begin
			state_q      <= state_d;
			item_count_q <= item_count_d;
			max_length_q <= max_length_d;
			overflow_q   <= overflow_d;
			lo_q         <= lo_d;
			hi1_q        <= hi1_d;
			mid_q        <= mid_d;
			answer_q     <= answer_d;
			exact_q      <= exact_d;
			empty_q      <= empty_d;
			walk_q       <= walk_d;
			drain_q      <= drain_d;
			out_valid_q  <= out_valid_d;
			rv_s1        <= ram_re;
			first_s1     <= ram_re && (walk_q == '0);
			v_s2         <= rv_s1;
			first_s2     <= first_s1;
		end
	end

	// Excess of the length read this cycle over the current probe height.
	assign excess = (ram_rdata > mid_q) ? (ram_rdata - mid_q) : '0;

	always_ff @(posedge clk) begin
		excess_s2 <= excess;
		if (load_out) begin
			cut_height_q   <= answer_q;
			exact_out_q    <= exact_q;
			overflow_out_q <= overflow_q;
			empty_out_q    <= empty_q;
		end
	end

	assign link[0].clear  = v_s2 && first_s2;
	assign link[0].carry  = 1'b0;
	assign link[0].addend = v_s2 ? tcbs_pkg::CHAIN_W'(excess_s2) : '0;

	for (genvar k = 0; k < tcbs_pkg::NUM_CELLS; k++) begin : g_cell
		tcbs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.link_in  (link[k]),
			.link_out (link[k+1]),
			.acc      (acc_slice[k])
		);
		assign chain_sum[k*tcbs_pkg::SLICE_W +: tcbs_pkg::SLICE_W] = acc_slice[k];
	end

	assign target_ext = tcbs_pkg::CHAIN_W'(target_q);

	assign out_valid   = out_valid_q;
	assign cut_height  = cut_height_q;
	assign exact_match = exact_out_q;
	assign overflow    = overflow_out_q;
	assign empty_set   = empty_out_q;

	`TCBS_ASSERT(a_no_sum_wrap, clk, arst_n, !link[tcbs_pkg::NUM_CELLS].carry)
	`TCBS_ASSERT(a_count_bound, clk, arst_n,
		item_count_q <= tcbs_pkg::CNT_W'(tcbs_pkg::MAX_ITEMS))
	`TCBS_ASSERT_IMPL(a_walk_in_set, clk, arst_n, state_q == tcbs_pkg::ST_WALK,
		walk_q < item_count_q)
	`TCBS_ASSERT_IMPL(a_result_source, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == tcbs_pkg::ST_FINISH)
	`TCBS_ASSERT_IMPL(a_empty_result, clk, arst_n, out_valid_q && empty_out_q,
		(cut_height_q == '0) && !exact_out_q)

endmodule

// ----- rtl/tcbs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tcbs_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tcbs_cell.sv -----
// One slice of the carry-pipelined excess accumulator chain.
module tcbs_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tcbs_pkg::cell_link_t                link_in,
	output tcbs_pkg::cell_link_t                link_out,
	output logic [tcbs_pkg::SLICE_W-1:0]        acc
);

	logic [tcbs_pkg::SLICE_W-1:0] acc_q;
	logic [tcbs_pkg::SLICE_W-1:0] base;
	logic [tcbs_pkg::SLICE_W:0]   slice_sum;
	tcbs_pkg::cell_link_t         link_q;

	always_comb begin
		base      = link_in.clear ? '0 : acc_q;
		slice_sum = {1'b0, base} + {1'b0, link_in.addend[tcbs_pkg::SLICE_W-1:0]}
			+ {{tcbs_pkg::SLICE_W{1'b0}}, link_in.carry};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			link_q <= '0;
		end else begin
			acc_q         <= slice_sum[tcbs_pkg::SLICE_W-1:0];
			link_q.clear  <= link_in.clear;
			link_q.carry  <= slice_sum[tcbs_pkg::SLICE_W];
			link_q.addend <= link_in.addend >> tcbs_pkg::SLICE_W;
		end
	end

	assign link_out = link_q;
	assign acc      = acc_q;

endmodule
